@@ sv/csvv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character codes and cell helper functions for the CSV stream validator.
package csvv_pkg;

  localparam int POSITION_BITS   = 32;
  localparam int CELL_COUNT_BITS = 16;
  localparam int LINE_BITS       = 32;
  localparam int OUT_POS_BITS    = 32;
  localparam int OUT_COUNT_BITS  = 16;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;

  // Lines with fewer bytes than this before the CR are too short.
  localparam logic [1:0] MIN_LINE_LEN = 2'd3;

  typedef logic [POSITION_BITS-1:0]   pos_t;
  typedef logic [CELL_COUNT_BITS-1:0] cnt_t;
  typedef logic [LINE_BITS-1:0]       line_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_COMMA    = 3'd1,
    ST_SHORT    = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_HALF     = 3'd4,
    ST_ODD      = 3'd5,
    ST_STRAY    = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic nonempty;
    logic starts_quote;
    logic last_quote;
    logic odd;
    logic any_quote;
  } cell_flags_t;

  typedef struct packed {
    status_e code;
    pos_t    pos;
    line_t   line;
  } err_t;

  typedef struct packed {
    status_e code;
    pos_t    pos;
    line_t   line;
    cnt_t    exp;
    cnt_t    found;
  } rep_t;

  typedef struct packed {
    status_e                   status;
    logic [OUT_POS_BITS-1:0]   position;
    logic [LINE_BITS-1:0]      line_number;
    logic [OUT_COUNT_BITS-1:0] expected_count;
    logic [OUT_COUNT_BITS-1:0] found_count;
  } result_t;

  // Adds one ordinary byte to the flags of the open cell.
  function automatic cell_flags_t cell_add(cell_flags_t f, logic [7:0] b);
    cell_flags_t r;
    logic        q;
    r = f;
    q = (b == CHAR_QUOTE);
    if (!f.nonempty) begin
      r.nonempty     = 1'b1;
      r.starts_quote = q;
    end
    r.last_quote = q;
    if (q) begin
      r.odd       = !f.odd;
      r.any_quote = 1'b1;
    end
    return r;
  endfunction

  // Quote rule verdict for a cell that is being closed.
  function automatic status_e cell_code(cell_flags_t f);
    status_e c;
    c = ST_OK;
    if (f.nonempty && f.starts_quote) begin
      if (!f.last_quote) begin
        c = ST_HALF;
      end else if (f.odd) begin
        c = ST_ODD;
      end
    end else if (f.any_quote) begin
      c = ST_STRAY;
    end
    return c;
  endfunction

  function automatic result_t to_result(rep_t r);
    result_t o;
    o.status         = r.code;
    o.position       = OUT_POS_BITS'(r.pos);
    o.line_number    = r.line;
    o.expected_count = OUT_COUNT_BITS'(r.exp);
    o.found_count    = OUT_COUNT_BITS'(r.found);
    return o;
  endfunction

endpackage

@@ sv/csvv_in_reg.sv @@
`timescale 1ns / 1ps
// Input register that holds one accepted byte item until the scanner takes it.
module csvv_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  input  logic           advance,
  output logic           item_valid,
  output csvv_pkg::item_t item
);
  import csvv_pkg::*;

  logic accept;

  assign in_ready = !item_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.data_byte <= data_byte;
      item.last_byte <= last_byte;
    end
  end

endmodule

@@ sv/csvv_core.sv @@
`timescale 1ns / 1ps
// Scanner state and the combinational next-state logic for one byte.
module csvv_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  csvv_pkg::item_t   item,
  output csvv_pkg::result_t result_next
);
  import csvv_pkg::*;

  logic        inside_quotes, inside_quotes_next;
  logic        cr_pending, cr_pending_next;
  logic        prev_comma, prev_comma_next;
  logic        comma_before_cr, comma_before_cr_next;
  logic        first_line_seen, first_line_seen_next;
  pos_t        byte_position, byte_position_next;
  pos_t        line_start_pos, line_start_pos_next;
  pos_t        cell_start_pos, cell_start_pos_next;
  logic [1:0]  line_length, line_length_next;
  cnt_t        cell_count, cell_count_next;
  cnt_t        expected_cells, expected_cells_next;
  line_t       line_counter, line_counter_next;
  cell_flags_t cell_flags, cell_flags_next;
  err_t        line_cell_error, line_cell_error_next;
  logic        held_valid, held_valid_next;
  pos_t        held_pos, held_pos_next;
  line_t       held_line, held_line_next;
  cnt_t        held_exp, held_exp_next;
  err_t        held_cell_error, held_cell_error_next;
  rep_t        verdict, verdict_next;
  err_t        comma_error, comma_error_next;

  line_t       line_no;
  status_e     close_code;
  logic        line_done;
  logic [7:0]  b;
  rep_t        sel;

  assign line_no = line_counter + line_t'(1);
  assign b       = item.data_byte;

  always_comb begin
    inside_quotes_next   = inside_quotes;
    cr_pending_next      = cr_pending;
    prev_comma_next      = prev_comma;
    comma_before_cr_next = comma_before_cr;
    first_line_seen_next = first_line_seen;
    byte_position_next   = byte_position;
    line_start_pos_next  = line_start_pos;
    cell_start_pos_next  = cell_start_pos;
    line_length_next     = line_length;
    cell_count_next      = cell_count;
    expected_cells_next  = expected_cells;
    line_counter_next    = line_counter;
    cell_flags_next      = cell_flags;
    line_cell_error_next = line_cell_error;
    held_valid_next      = held_valid;
    held_pos_next        = held_pos;
    held_line_next       = held_line;
    held_exp_next        = held_exp;
    held_cell_error_next = held_cell_error;
    verdict_next         = verdict;
    comma_error_next     = comma_error;
    close_code           = ST_OK;
    line_done            = 1'b0;
    sel                  = '0;

    if (step) begin
      if (comma_error.code == ST_OK) begin
        if (cr_pending) begin
          cr_pending_next = 1'b0;
          if (b == CHAR_LF) begin
            line_done  = 1'b1;
            close_code = cell_code(cell_flags);
            if (close_code != ST_OK && line_cell_error.code == ST_OK) begin
              line_cell_error_next = '{code: close_code, pos: cell_start_pos, line: line_no};
            end
            if (comma_before_cr) begin
              comma_error_next = '{code: ST_COMMA, pos: byte_position - pos_t'(2),
                                   line: line_no};
            end else if (verdict.code == ST_OK) begin
              if (held_valid) begin
                verdict_next = '{code: ST_MISMATCH, pos: held_pos, line: held_line,
                                 exp: held_exp, found: cnt_t'(1)};
              end else if (line_length < MIN_LINE_LEN) begin
                verdict_next = '{code: ST_SHORT, pos: line_start_pos, line: line_no,
                                 exp: '0, found: '0};
              end else if (!first_line_seen) begin
                first_line_seen_next = 1'b1;
                expected_cells_next  = cell_count;
                verdict_next = '{code: line_cell_error_next.code,
                                 pos: line_cell_error_next.pos,
                                 line: line_cell_error_next.line, exp: '0, found: '0};
              end else if (cell_count != expected_cells) begin
                if (cell_count == cnt_t'(1)) begin
                  // A one-cell line may be the exempt final line: hold the error.
                  held_valid_next      = 1'b1;
                  held_pos_next        = line_start_pos;
                  held_line_next       = line_no;
                  held_exp_next        = expected_cells;
                  held_cell_error_next = line_cell_error_next;
                end else begin
                  verdict_next = '{code: ST_MISMATCH, pos: line_start_pos, line: line_no,
                                   exp: expected_cells, found: cell_count};
                end
              end else begin
                verdict_next = '{code: line_cell_error_next.code,
                                 pos: line_cell_error_next.pos,
                                 line: line_cell_error_next.line, exp: '0, found: '0};
              end
            end
            line_counter_next    = line_no;
            line_start_pos_next  = byte_position + pos_t'(1);
            cell_start_pos_next  = byte_position + pos_t'(1);
            cell_flags_next      = '0;
            cell_count_next      = cnt_t'(1);
            line_length_next     = '0;
            line_cell_error_next = '0;
            prev_comma_next      = 1'b0;
          end else begin
            // A lone CR is an ordinary cell byte.
            cell_flags_next = cell_add(cell_flags_next, CHAR_CR);
            if (line_length_next != 2'd3) begin
              line_length_next = line_length_next + 2'd1;
            end
          end
        end

        if (!line_done) begin
          inside_quotes_next = inside_quotes ^ (b == CHAR_QUOTE);
          if (b == CHAR_CR && !inside_quotes_next) begin
            cr_pending_next      = 1'b1;
            comma_before_cr_next = prev_comma;
          end else if (b == CHAR_COMMA && !inside_quotes_next) begin
            close_code = cell_code(cell_flags_next);
            if (close_code != ST_OK && line_cell_error.code == ST_OK) begin
              line_cell_error_next = '{code: close_code, pos: cell_start_pos, line: line_no};
            end
            if (line_length_next != 2'd3) begin
              line_length_next = line_length_next + 2'd1;
            end
            if (cell_count != '1) begin
              cell_count_next = cell_count + cnt_t'(1);
            end
            cell_start_pos_next = byte_position + pos_t'(1);
            cell_flags_next     = '0;
          end else begin
            cell_flags_next = cell_add(cell_flags_next, b);
            if (line_length_next != 2'd3) begin
              line_length_next = line_length_next + 2'd1;
            end
          end
          prev_comma_next = (b == CHAR_COMMA);
        end
      end

      byte_position_next = byte_position + pos_t'(1);

      if (item.last_byte) begin
        if (comma_error_next.code != ST_OK) begin
          sel = '{code: comma_error_next.code, pos: comma_error_next.pos,
                  line: comma_error_next.line, exp: '0, found: '0};
        end else if (verdict_next.code != ST_OK) begin
          sel = verdict_next;
        end else if (held_valid_next) begin
          sel = '{code: held_cell_error_next.code, pos: held_cell_error_next.pos,
                  line: held_cell_error_next.line, exp: '0, found: '0};
        end
        if (sel.code == ST_OK) begin
          sel = '0;
        end
        // The stream is over: everything returns to its reset values.
        inside_quotes_next   = 1'b0;
        cr_pending_next      = 1'b0;
        prev_comma_next      = 1'b0;
        comma_before_cr_next = 1'b0;
        first_line_seen_next = 1'b0;
        byte_position_next   = '0;
        line_start_pos_next  = '0;
        cell_start_pos_next  = '0;
        line_length_next     = '0;
        cell_count_next      = cnt_t'(1);
        expected_cells_next  = '0;
        line_counter_next    = '0;
        cell_flags_next      = '0;
        line_cell_error_next = '0;
        held_valid_next      = 1'b0;
        held_pos_next        = '0;
        held_line_next       = '0;
        held_exp_next        = '0;
        held_cell_error_next = '0;
        verdict_next         = '0;
        comma_error_next     = '0;
      end
    end
  end

  assign result_next = to_result(sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes   <= 1'b0;
      cr_pending      <= 1'b0;
      prev_comma      <= 1'b0;
      comma_before_cr <= 1'b0;
      first_line_seen <= 1'b0;
      byte_position   <= '0;
      line_start_pos  <= '0;
      cell_start_pos  <= '0;
      line_length     <= '0;
      cell_count      <= cnt_t'(1);
      expected_cells  <= '0;
      line_counter    <= '0;
      cell_flags      <= '0;
      line_cell_error <= '0;
      held_valid      <= 1'b0;
      held_pos        <= '0;
      held_line       <= '0;
      held_exp        <= '0;
      held_cell_error <= '0;
      verdict         <= '0;
      comma_error     <= '0;
    end else begin
      inside_quotes   <= inside_quotes_next;
      cr_pending      <= cr_pending_next;
      prev_comma      <= prev_comma_next;
      comma_before_cr <= comma_before_cr_next;
      first_line_seen <= first_line_seen_next;
      byte_position   <= byte_position_next;
      line_start_pos  <= line_start_pos_next;
      cell_start_pos  <= cell_start_pos_next;
      line_length     <= line_length_next;
      cell_count      <= cell_count_next;
      expected_cells  <= expected_cells_next;
      line_counter    <= line_counter_next;
      cell_flags      <= cell_flags_next;
      line_cell_error <= line_cell_error_next;
      held_valid      <= held_valid_next;
      held_pos        <= held_pos_next;
      held_line       <= held_line_next;
      held_exp        <= held_exp_next;
      held_cell_error <= held_cell_error_next;
      verdict         <= verdict_next;
      comma_error     <= comma_error_next;
    end
  end

  a_end_clears_position: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> byte_position == '0 && cell_count == cnt_t'(1))
    else $error("stream end did not return the scanner to its start state");

  a_comma_error_sticky: assert property (@(posedge clk) disable iff (rst)
    comma_error.code != ST_OK && !(step && item.last_byte) |=> comma_error.code != ST_OK)
    else $error("comma error was lost before the stream ended");

  a_held_needs_first_line: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> first_line_seen && cell_count != '0)
    else $error("held mismatch without a first line");

endmodule

@@ sv/csvv_out_reg.sv @@
`timescale 1ns / 1ps
// Result register that holds the verdict until the consumer takes it.
module csvv_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  csvv_pkg::result_t result_in,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              slot_free,
  output csvv_pkg::result_t result
);
  import csvv_pkg::*;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

  a_ok_is_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.status == ST_OK |-> result.position == '0 &&
    result.line_number == '0)
    else $error("ok verdict carries a position or line");

  a_counts_only_on_mismatch: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.status != ST_MISMATCH |->
    result.expected_count == '0 && result.found_count == '0)
    else $error("cell counts reported for a status other than mismatch");

endmodule

@@ sv/csv_stream_validator_unit.sv @@
`timescale 1ns / 1ps
// Top level of the CSV stream validator: input register, scanner and result register.
// The verdict enters the result register at the edge where the final byte item leaves
// the input register.
// Throughput: one byte item per cycle; the scanner forms its next state combinationally.
// A final byte waits in the input register only while an earlier verdict is still untaken.
// Reset (rst, synchronous, active high) empties both registers and puts the scanner at the
// start of a new stream; the scanner also returns there by itself after every final byte.
module csv_stream_validator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] position,
  output logic [31:0] line_number,
  output logic [15:0] expected_count,
  output logic [15:0] found_count
);
  import csvv_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    slot_free;
  logic    advance;
  result_t result_next;
  result_t result;

  // Ordinary bytes never produce a result, so they move on even while a verdict
  // waits at the output. Only a final byte needs a free result register.
  assign advance = item_valid && (!item.last_byte || slot_free);

  csvv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // The scanner tracks quoting, cells and lines, and on the final byte forms the verdict.
  csvv_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (item),
    .result_next (result_next)
  );

  csvv_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && item.last_byte),
    .result_in (result_next),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .slot_free (slot_free),
    .result    (result)
  );

  assign status         = result.status;
  assign position       = result.position;
  assign line_number    = result.line_number;
  assign expected_count = result.expected_count;
  assign found_count    = result.found_count;

endmodule

@@ test/csv_stream_validator_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the CSV stream validator: directed and random CSV streams.
module csv_stream_validator_unit_test;
  import csvv_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_BYTES = 450;
  localparam int SETTLE      = 8;

  // Shapes of the cells that the stream builder can emit.
  typedef enum int {
    CELL_PLAIN,
    CELL_EMPTY,
    CELL_QUOTED,
    CELL_HALF,
    CELL_STRAY,
    CELL_OPEN_QUOTE,
    CELL_LONE_CR
  } cell_kind_e;

  // At most one defect is planted in a generated stream.
  typedef enum int {
    DEF_NONE,
    DEF_TRAILING_COMMA,
    DEF_SHORT,
    DEF_FEWER,
    DEF_MORE,
    DEF_ONE_CELL,
    DEF_HALF,
    DEF_STRAY,
    DEF_OPEN_QUOTE,
    DEF_LONE_CR
  } defect_e;

  // Tracks the scanner state of the stream in flight and keeps the verdicts that are owed.
  class verdict_board;
    logic        quoted, cr_pend, prev_comma, comma_at_cr, seen_first;
    pos_t        byte_pos, line_start, cell_begin;
    cnt_t        cell_cnt, exp_cells;
    logic [1:0]  line_len;
    line_t       line_cnt;
    cell_flags_t flags;
    rep_t        cell_fault, held_count_fault, held_cell_fault, line_verdict, comma_fault;
    result_t     pending_verdicts[$];
    int unsigned failures;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      quoted           = 1'b0;
      cr_pend          = 1'b0;
      prev_comma       = 1'b0;
      comma_at_cr      = 1'b0;
      seen_first       = 1'b0;
      byte_pos         = '0;
      line_start       = '0;
      cell_begin       = '0;
      cell_cnt         = cnt_t'(1);
      exp_cells        = '0;
      line_len         = '0;
      line_cnt         = '0;
      flags            = '0;
      cell_fault       = '0;
      held_count_fault = '0;
      held_cell_fault  = '0;
      line_verdict     = '0;
      comma_fault      = '0;
    endfunction

    function rep_t make_report(status_e c, pos_t p, line_t l, cnt_t e, cnt_t f);
      rep_t r;
      r.code  = c;
      r.pos   = p;
      r.line  = l;
      r.exp   = e;
      r.found = f;
      return r;
    endfunction

    function void add_to_cell(logic [7:0] b);
      logic q;
      q = (b == CHAR_QUOTE);
      if (line_len < MIN_LINE_LEN) line_len++;
      if (!flags.nonempty) begin
        flags.nonempty     = 1'b1;
        flags.starts_quote = q;
      end
      flags.last_quote = q;
      if (q) begin
        flags.odd       = !flags.odd;
        flags.any_quote = 1'b1;
      end
    endfunction

    // Only the first quote fault of a line is remembered.
    function void close_cell();
      status_e c;
      c = ST_OK;
      if (flags.nonempty && flags.starts_quote) begin
        if (!flags.last_quote) begin
          c = ST_HALF;
        end else if (flags.odd) begin
          c = ST_ODD;
        end
      end else if (flags.any_quote) begin
        c = ST_STRAY;
      end
      if (c != ST_OK && cell_fault.code == ST_OK)
        cell_fault = make_report(c, cell_begin, line_cnt + 1, '0, '0);
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      pos_t    at;
      line_t   line_no;
      logic    line_done;
      rep_t    r;
      result_t v;
      at = byte_pos;
      line_done = 1'b0;
      // Once a comma before CRLF is found, only the final byte matters.
      if (comma_fault.code == ST_OK) begin
        if (cr_pend) begin
          cr_pend = 1'b0;
          if (b == CHAR_LF) begin
            line_no = line_cnt + 1;
            close_cell();
            if (comma_at_cr) begin
              comma_fault = make_report(ST_COMMA, at - 2, line_no, '0, '0);
            end else if (line_verdict.code == ST_OK) begin
              if (held_count_fault.code != ST_OK) begin
                line_verdict = held_count_fault;
              end else if (line_len < MIN_LINE_LEN) begin
                line_verdict = make_report(ST_SHORT, line_start, line_no, '0, '0);
              end else if (!seen_first) begin
                seen_first   = 1'b1;
                exp_cells    = cell_cnt;
                line_verdict = cell_fault;
              end else if (cell_cnt != exp_cells) begin
                // A one-cell line may be the final one, which is exempt, so hold it.
                if (cell_cnt == cnt_t'(1)) begin
                  held_count_fault = make_report(ST_MISMATCH, line_start, line_no, exp_cells,
                                                 cnt_t'(1));
                  held_cell_fault  = cell_fault;
                end else begin
                  line_verdict = make_report(ST_MISMATCH, line_start, line_no, exp_cells,
                                             cell_cnt);
                end
              end else begin
                line_verdict = cell_fault;
              end
            end
            line_cnt   = line_no;
            line_start = at + 1;
            cell_begin = at + 1;
            flags      = '0;
            cell_cnt   = cnt_t'(1);
            line_len   = '0;
            cell_fault = '0;
            prev_comma = 1'b0;
            line_done  = 1'b1;
          end else begin
            add_to_cell(CHAR_CR);
          end
        end
        if (!line_done) begin
          if (b == CHAR_QUOTE) quoted = !quoted;
          if (b == CHAR_CR && !quoted) begin
            cr_pend     = 1'b1;
            comma_at_cr = prev_comma;
          end else if (b == CHAR_COMMA && !quoted) begin
            close_cell();
            if (line_len < MIN_LINE_LEN) line_len++;
            if (cell_cnt != '1) cell_cnt++;
            cell_begin = at + 1;
            flags      = '0;
          end else begin
            add_to_cell(b);
          end
          prev_comma = (b == CHAR_COMMA);
        end
      end
      byte_pos = byte_pos + 1;
      if (last) begin
        if (comma_fault.code != ST_OK) r = comma_fault;
        else if (line_verdict.code != ST_OK) r = line_verdict;
        else if (held_count_fault.code != ST_OK) r = held_cell_fault;
        else r = '0;
        v.status         = r.code;
        v.position       = r.pos;
        v.line_number    = r.line;
        v.expected_count = r.exp;
        v.found_count    = r.found;
        pending_verdicts.push_back(v);
        restart();
      end
    endfunction

    function void compare_field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
        failures++;
      end
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict with none expected, got status %0d position %0d line %0d",
                 $time, got.status, got.position, got.line_number);
        failures++;
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("position", want.position, got.position);
        compare_field("line_number", want.line_number, got.line_number);
        compare_field("expected_count", want.expected_count, got.expected_count);
        compare_field("found_count", want.found_count, got.found_count);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] position;
  logic [31:0] line_number;
  logic [15:0] expected_count;
  logic [15:0] found_count;

  verdict_board board = new();

  logic [7:0]  csv_text[$];
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  int          hold_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_by_phase[4] = '{0, 62, 0, 38};
  int unsigned stall_by_phase[4] = '{0, 0, 62, 38};

  csv_stream_validator_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .position       (position),
    .line_number    (line_number),
    .expected_count (expected_count),
    .found_count    (found_count)
  );

  always #10 clk = ~clk;

  // Watchdog: a run that never drains its verdicts ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(negedge clk) begin
    if (hold_left == 0 && hold_done != hold_asked) begin
      hold_left = LONG_HOLD;
      hold_done = hold_done + 1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Verdicts are taken at the rising edge where valid and ready are both high.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_verdict(result_t'{status_e'(status), position, line_number,
                                    expected_count, found_count});
  end

  // Mostly text bytes; now and then any byte that is not a CSV delimiter.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(4) == 0) c = 8'($urandom_range(255));
    else c = 8'($urandom_range(8'h7A, 8'h61));
    if (c == CHAR_CR || c == CHAR_LF || c == CHAR_COMMA || c == CHAR_QUOTE) c = 8'h78;
    return c;
  endfunction

  // Raw bytes with the delimiters strongly favored.
  function automatic logic [7:0] noise_char();
    case ($urandom_range(7))
      0: return CHAR_CR;
      1: return CHAR_LF;
      2: return CHAR_COMMA;
      3: return CHAR_QUOTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic put_cell(input cell_kind_e kind, input int min_len);
    case (kind)
      CELL_PLAIN: begin
        repeat ($urandom_range(min_len + 3, min_len)) csv_text.push_back(plain_char());
      end
      CELL_EMPTY: begin
      end
      CELL_QUOTED: begin
        // Embedded delimiters and doubled quotes are all legal inside quotes.
        csv_text.push_back(CHAR_QUOTE);
        repeat ($urandom_range(4)) begin
          case ($urandom_range(5))
            0: begin
              csv_text.push_back(CHAR_QUOTE);
              csv_text.push_back(CHAR_QUOTE);
            end
            1: csv_text.push_back(CHAR_COMMA);
            2: csv_text.push_back(CHAR_CR);
            3: csv_text.push_back(CHAR_LF);
            default: csv_text.push_back(plain_char());
          endcase
        end
        csv_text.push_back(CHAR_QUOTE);
      end
      CELL_HALF: begin
        csv_text.push_back(CHAR_QUOTE);
        csv_text.push_back(plain_char());
        csv_text.push_back(CHAR_QUOTE);
        csv_text.push_back(plain_char());
      end
      CELL_STRAY: begin
        csv_text.push_back(plain_char());
        csv_text.push_back(CHAR_QUOTE);
        csv_text.push_back(plain_char());
        csv_text.push_back(CHAR_QUOTE);
      end
      CELL_OPEN_QUOTE: begin
        // An odd number of quotes leaves the rest of the stream quoted.
        csv_text.push_back(CHAR_QUOTE);
        csv_text.push_back(plain_char());
        csv_text.push_back(CHAR_QUOTE);
        csv_text.push_back(plain_char());
        csv_text.push_back(CHAR_QUOTE);
      end
      CELL_LONE_CR: begin
        csv_text.push_back(plain_char());
        csv_text.push_back(CHAR_CR);
        if ($urandom_range(1)) csv_text.push_back(CHAR_CR);
        csv_text.push_back(plain_char());
      end
      default: begin
      end
    endcase
  endtask

  // Builds one stream: usually a well-formed table with at most one planted defect,
  // sometimes pure noise.
  task automatic build_stream();
    int         cols, lines, bad_line, bad_col, n, pick;
    defect_e    defect;
    cell_kind_e kind;
    csv_text.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(16, 1)) csv_text.push_back(noise_char());
    end else begin
      cols     = ($urandom_range(9) == 0) ? $urandom_range(9, 5) : $urandom_range(4, 1);
      lines    = $urandom_range(5, 1);
      defect   = ($urandom_range(99) < 35) ? defect_e'($urandom_range(int'(DEF_LONE_CR), 1))
                                           : DEF_NONE;
      bad_line = $urandom_range(lines - 1);
      for (int l = 0; l < lines; l++) begin
        n = cols;
        if (l == bad_line) begin
          case (defect)
            DEF_FEWER:    n = (cols > 1) ? cols - 1 : cols + 1;
            DEF_MORE:     n = cols + 1;
            DEF_ONE_CELL: n = 1;
            default: ;
          endcase
        end
        bad_col = $urandom_range(n - 1);
        if (l == bad_line && defect == DEF_SHORT) begin
          repeat ($urandom_range(2)) csv_text.push_back(plain_char());
        end else begin
          for (int c = 0; c < n; c++) begin
            if (c > 0) csv_text.push_back(CHAR_COMMA);
            pick = $urandom_range(99);
            if (pick < 55) kind = CELL_PLAIN;
            else if (pick < 70 && n > 1) kind = CELL_EMPTY;
            else if (pick < 70) kind = CELL_PLAIN;
            else kind = CELL_QUOTED;
            if (l == bad_line && c == bad_col) begin
              case (defect)
                DEF_HALF:       kind = CELL_HALF;
                DEF_STRAY:      kind = CELL_STRAY;
                DEF_OPEN_QUOTE: kind = CELL_OPEN_QUOTE;
                DEF_LONE_CR:    kind = CELL_LONE_CR;
                default: ;
              endcase
            end
            put_cell(kind, (n == 1) ? 3 : 1);
          end
        end
        if (l == bad_line && defect == DEF_TRAILING_COMMA) csv_text.push_back(CHAR_COMMA);
        // The last line is sometimes left without its CRLF.
        if (l < lines - 1 || $urandom_range(3) != 0) begin
          csv_text.push_back(CHAR_CR);
          csv_text.push_back(CHAR_LF);
        end
      end
      if ($urandom_range(99) < 12) repeat ($urandom_range(3, 1)) csv_text.push_back(noise_char());
    end
    if (csv_text.size() == 0) csv_text.push_back(plain_char());
  endtask

  // Offers one item and returns at the rising edge where it is accepted.
  // Valid is left high so that a following item goes out without a gap.
  task automatic send_byte(input logic [7:0] b, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_stream();
    foreach (csv_text[i]) send_byte(csv_text[i], i == csv_text.size() - 1);
  endtask

  task automatic send_text(input string s);
    csv_text.delete();
    for (int i = 0; i < s.len(); i++) csv_text.push_back(s[i]);
    send_stream();
  endtask

  // Drops valid and waits until every owed verdict has been checked.
  task automatic wait_for_verdicts();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_verdicts.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed streams: a lone 0xFF byte with no line end, a comma right before
    // CRLF, a line that is too short, a half quoted cell and a stray quote.
    send_text("\377");
    send_text(",\015\012");
    send_text("a\015\012");
    send_text("\"a\"b,c\015\012");
    send_text("a\"b\",c\015\012");
    wait_for_verdicts();

    for (int phase = 0; phase < 4; phase++) begin
      int unsigned phase_start;
      sender_idle_pct = idle_by_phase[phase];
      stall_pct       = stall_by_phase[phase];
      phase_start     = bytes_sent;
      if (phase == 0) begin
        // The result side holds off while several streams are offered, so the result
        // register holds a finished verdict and the block stops taking bytes.
        hold_asked = hold_asked + 1;
        repeat (12) begin
          build_stream();
          send_stream();
        end
      end
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_stream();
        send_stream();
      end
      wait_for_verdicts();
    end

    repeat (SETTLE) @(posedge clk);
    if (board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
